@@ rtl/rdt_pkg.sv @@
// Package with shared types and constants of the request dedup table.
package rdt_pkg;

    localparam int unsigned TableSlotsDefault = 64;
    localparam logic [31:0] LifetimeReset = 32'd60000;

    localparam logic [2:0] ACT_BEGIN   = 3'd0;
    localparam logic [2:0] ACT_PERSIST = 3'd1;
    localparam logic [2:0] ACT_RESPOND = 3'd2;
    localparam logic [2:0] ACT_SEED    = 3'd3;
    localparam logic [2:0] ACT_ABANDON = 3'd4;
    localparam logic [2:0] ACT_FIND    = 3'd5;

    localparam logic [3:0] ST_STARTED  = 4'd0;
    localparam logic [3:0] ST_REPLAY   = 4'd1;
    localparam logic [3:0] ST_INPROG   = 4'd2;
    localparam logic [3:0] ST_DONE     = 4'd3;
    localparam logic [3:0] ST_NOTFOUND = 4'd4;
    localparam logic [3:0] ST_NORECORD = 4'd5;
    localparam logic [3:0] ST_BADSTATE = 4'd6;
    localparam logic [3:0] ST_TXNOPEN  = 4'd7;
    localparam logic [3:0] ST_ZEROKEY  = 4'd8;
    localparam logic [3:0] ST_FULL     = 4'd9;

    localparam logic [1:0] PH_NONE      = 2'd0;
    localparam logic [1:0] PH_RECEIVED  = 2'd1;
    localparam logic [1:0] PH_PERSISTED = 2'd2;
    localparam logic [1:0] PH_RESPONDED = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] request_id;
        logic [31:0] result_tag;
        logic        txn_open;
        logic [31:0] time_now;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  entry_state;
        logic [31:0] stored_tag;
    } rsp_t;

    // Front classification handed to the back part.
    typedef struct packed {
        req_t       req;
        logic       early;      // answered without a table search
        logic [3:0] early_status;
    } cmd_t;

endpackage

@@ rtl/rdt_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface rdt_req_if;
    logic           valid;
    logic           ready;
    rdt_pkg::req_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rdt_rsp_if;
    logic           valid;
    logic           ready;
    rdt_pkg::rsp_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rdt_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module rdt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/rdt_front.sv @@
// Front part: accepts requests, screens trivial errors, fills a two-entry queue.
module rdt_front (
    input  logic           clk,
    input  logic           rst_n,
    rdt_req_if.sink        req,
    output logic           cmd_valid,
    output rdt_pkg::cmd_t  cmd,
    input  logic           cmd_take
);
    import rdt_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push;

    always_comb
    begin
        c.req = req.payload;
        c.early = 1'b1;
        c.early_status = ST_BADSTATE;
        if (req.payload.action == ACT_PERSIST && req.payload.txn_open)
        begin
            c.early_status = ST_TXNOPEN;
        end
        else if (req.payload.action <= ACT_ABANDON && req.payload.request_id == 64'd0)
        begin
            c.early_status = ST_ZEROKEY;
        end
        else if (req.payload.action == ACT_FIND && req.payload.request_id == 64'd0)
        begin
            c.early_status = ST_NOTFOUND;
        end
        else if (req.payload.action <= ACT_FIND)
        begin
            c.early = 1'b0;
        end
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_take)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
        end
        else
        begin
            assert (!(cmd_take && !cmd_valid))
                else $error("queue read while empty");
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) cnt_reg == 2'd2 |-> !req.ready;
    endproperty
    assert property (p_no_overflow) else $error("queue overflow");

    property p_count_grow;
        @(posedge clk) disable iff (!rst_n)
            (push && !cmd_take) |=> cnt_reg == $past(cnt_reg) + 2'd1;
    endproperty
    assert property (p_count_grow) else $error("queue count lost a push");

    property p_take_valid;
        @(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid;
    endproperty
    assert property (p_take_valid) else $error("take from empty queue");
endmodule

@@ rtl/rdt_back.sv @@
// Back part: scans the table one slot a cycle, updates it and registers the response.
module rdt_back #(
    parameter int unsigned TABLE_SLOTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           cmd_valid,
    input  rdt_pkg::cmd_t  cmd,
    output logic           cmd_take,
    rdt_rsp_if.source      rsp
);
    import rdt_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SLOTS);
    localparam logic [AW:0] LAST_IDX = (AW+1)'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_LAST, S_READ, S_WAIT, S_EXEC
    } state_t;

    state_t      state_reg;
    logic [AW:0] idx_reg;
    logic [AW-1:0] ridx;
    logic [31:0] life_reg;
    cmd_t        cur_reg;
    logic        hit_reg, emp_reg, exp_reg;
    logic [AW-1:0] hit_idx_reg, emp_idx_reg, exp_idx_reg;
    logic [AW-1:0] sel_reg;
    logic [AW-1:0] sel_pick;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [63:0]   key_rd;
    logic [31:0]   tag_rd, dl_rd, tag_wd, dl_wd;
    logic [1:0]    ph_rd;
    logic          key_we, tag_we, dl_we;
    logic [1:0]    ph_wd;
    logic          ph_we;
    logic [32:0]   dsum;
    logic [31:0]   new_dl;
    logic [AW-1:0] prev;
    logic          live_sel;
    logic [1:0]    ph_sel;
    rsp_t          res;

    // The chosen slot: the matching key, then the lowest empty, then the lowest expired.
    assign sel_pick = hit_reg ? hit_idx_reg : (emp_reg ? emp_idx_reg : exp_idx_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:         ridx = '0;
            S_SCAN, S_LAST: ridx = idx_reg[AW-1:0];
            S_READ:         ridx = sel_pick;
            default:        ridx = sel_reg;
        endcase
    end

    rdt_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_key (
        .clk(clk), .we(key_we), .waddr(waddr), .wdata(cur_reg.req.request_id),
        .raddr(ridx), .rdata(key_rd));
    rdt_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_tag (
        .clk(clk), .we(tag_we), .waddr(waddr), .wdata(tag_wd),
        .raddr(ridx), .rdata(tag_rd));
    rdt_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_dl (
        .clk(clk), .we(dl_we), .waddr(waddr), .wdata(dl_wd),
        .raddr(ridx), .rdata(dl_rd));
    rdt_ram #(.WIDTH(2), .DEPTH(TABLE_SLOTS)) u_ph (
        .clk(clk), .we(ph_we), .waddr(waddr), .wdata(ph_wd),
        .raddr(ridx), .rdata(ph_rd));

    assign dsum   = {1'b0, cur_reg.req.time_now} + {1'b0, life_reg};
    assign new_dl = dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
    assign prev   = idx_reg[AW-1:0] - 1'b1;
    assign ph_sel = ph_rd;
    assign live_sel = (ph_sel != PH_NONE) && (cur_reg.req.time_now < dl_rd);

    // Table writes happen in S_EXEC, and phase clearing in S_CLEAR after reset.
    always_comb
    begin
        res = '{status: ST_BADSTATE, entry_state: PH_NONE, stored_tag: 32'd0};
        ph_we = 1'b0; ph_wd = PH_NONE; key_we = 1'b0; tag_we = 1'b0; dl_we = 1'b0;
        tag_wd = 32'd0; dl_wd = new_dl; waddr = sel_reg; we = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            ph_we = 1'b1;
            waddr = idx_reg[AW-1:0];
        end
        if (state_reg == S_EXEC)
        begin
            if (cur_reg.early)
            begin
                res.status = cur_reg.early_status;
            end
            else
            begin
                case (cur_reg.req.action)
                    ACT_BEGIN:
                    begin
                        if (hit_reg && live_sel)
                        begin
                            if (ph_sel != PH_RECEIVED)
                            begin
                                res = '{status: ST_REPLAY, entry_state: ph_sel,
                                        stored_tag: tag_rd};
                            end
                            else
                            begin
                                res.status = ST_INPROG;
                                res.entry_state = PH_RECEIVED;
                            end
                        end
                        else if (hit_reg || emp_reg || exp_reg)
                        begin
                            we = 1'b1; ph_wd = PH_RECEIVED;
                            res.status = ST_STARTED; res.entry_state = PH_RECEIVED;
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                    ACT_PERSIST:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1; ph_wd = PH_PERSISTED; tag_wd = cur_reg.req.result_tag;
                            res.status = ST_DONE; res.entry_state = PH_PERSISTED;
                        end
                        else
                        begin
                            res.status = ST_NORECORD;
                        end
                    end
                    ACT_RESPOND:
                    begin
                        if (!hit_reg)
                        begin
                            res.status = ST_NORECORD;
                        end
                        else if (ph_sel != PH_PERSISTED)
                        begin
                            res.entry_state = ph_sel;
                        end
                        else
                        begin
                            ph_we = 1'b1; ph_wd = PH_RESPONDED;
                            res.status = ST_DONE; res.entry_state = PH_RESPONDED;
                        end
                    end
                    ACT_SEED:
                    begin
                        if (hit_reg || emp_reg || exp_reg)
                        begin
                            we = 1'b1; ph_wd = PH_PERSISTED; tag_wd = cur_reg.req.result_tag;
                            res.status = ST_DONE; res.entry_state = PH_PERSISTED;
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                    ACT_ABANDON:
                    begin
                        ph_we = hit_reg; ph_wd = PH_NONE;
                        res.status = ST_DONE;
                    end
                    ACT_FIND:
                    begin
                        if (hit_reg && live_sel)
                        begin
                            res.status = ST_DONE; res.entry_state = ph_sel;
                        end
                        else
                        begin
                            res.status = ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        res.status = ST_BADSTATE;
                    end
                endcase
            end
            if (we)
            begin
                ph_we = 1'b1; key_we = 1'b1; tag_we = 1'b1; dl_we = 1'b1;
            end
        end
    end

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            life_reg      <= LifetimeReset;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                life_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg <= cmd;
                        hit_reg <= 1'b0; emp_reg <= 1'b0; exp_reg <= 1'b0;
                        idx_reg <= {{AW{1'b0}}, 1'b1};
                        state_reg <= cmd.early ? S_WAIT : S_SCAN;
                    end
                end
                S_SCAN, S_LAST:
                begin
                    // Data read for slot prev is present now.
                    if (ph_rd != PH_NONE)
                    begin
                        if (!hit_reg && key_rd == cur_reg.req.request_id)
                        begin
                            hit_reg <= 1'b1; hit_idx_reg <= prev;
                        end
                        if (!exp_reg && !(cur_reg.req.time_now < dl_rd))
                        begin
                            exp_reg <= 1'b1; exp_idx_reg <= prev;
                        end
                    end
                    else if (!emp_reg)
                    begin
                        emp_reg <= 1'b1; emp_idx_reg <= prev;
                    end
                    if (state_reg == S_LAST)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_LAST;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!rsp_valid_reg)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    rsp_reg       <= res;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            sel_reg <= sel_pick;
        end
    end

    property p_one_result;
        @(posedge clk) disable iff (!rst_n)
            state_reg == S_EXEC |-> !rsp_valid_reg;
    endproperty
    assert property (p_one_result) else $error("response overwritten");

    property p_take_idle;
        @(posedge clk) disable iff (!rst_n) cmd_take |=> state_reg != S_IDLE;
    endproperty
    assert property (p_take_idle) else $error("command taken but not started");

    property p_exec_once;
        @(posedge clk) disable iff (!rst_n) state_reg == S_EXEC |=> state_reg == S_IDLE;
    endproperty
    assert property (p_exec_once) else $error("execute lasted more than a cycle");
endmodule

@@ rtl/request_dedup_table_with_expiry_top.sv @@
// Top level of the request dedup table with expiry.
// Usage:
//   req: valid/ready transfer of one request (action, key, tag, txn flag, time).
//   rsp: valid/ready transfer of exactly one response per request.
//   cfg_we/cfg_wdata: write entry_lifetime; write only while the block is idle.
// A table request, from acceptance to response, takes a slot scan of one memory
// read per cycle, a re-read of the chosen slot, then the update; requests
// screened out early skip the scan and the re-read.
// The engine takes a new request only once the last one is done; the scan
// through the single read port of the slot memories sets its pace.
// A two-entry queue sits between the front and the table engine, so requests
// are accepted while a response still waits on a stalled receiver.
// At reset entry_lifetime is 60000, and the engine marks every slot empty
// before it takes its first request.
// A stalled receiver holds the engine before its update; no response is lost.
module request_dedup_table_with_expiry_top #(
    parameter int unsigned TABLE_SLOTS = rdt_pkg::TableSlotsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    rdt_req_if.sink     req,
    rdt_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import rdt_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    rdt_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take));

    rdt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take), .rsp(rsp));
endmodule
